/* hw/rtl/atcr_pkg.sv */
`default_nettype none
package atcr_pkg;

    localparam logic [7:0] BODY_MAX = 8'd128;

    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_ARM    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_CANCEL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PS_WAIT_A  = 2'd0,
        PS_WAIT_T  = 2'd1,
        PS_BODY    = 2'd2,
        PS_WAIT_LF = 2'd3
    } t_parse_step;

    typedef enum logic [3:0] {
        ST_LINE_OK   = 4'd0,
        ST_WAIT_T    = 4'd1,
        ST_IN_BODY   = 4'd2,
        ST_WAIT_LF   = 4'd3,
        ST_EARLY_CR  = 4'd4,
        ST_NO_LF     = 4'd5,
        ST_NOT_A     = 4'd6,
        ST_NOT_T     = 4'd7,
        ST_OVERFLOW  = 4'd8,
        ST_BULK_BYTE = 4'd9,
        ST_BULK_DONE = 4'd10,
        ST_ACK       = 4'd11
    } t_status;

endpackage
`default_nettype wire

/* hw/rtl/atcr_if.sv */
`default_nettype none
interface atcr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  byte_in;
    logic [15:0] bulk_length;

    modport source (output valid, output op, output byte_in, output bulk_length, input ready);
    modport sink   (input valid, input op, input byte_in, input bulk_length, output ready);
endinterface

interface atcr_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic        store_valid;
    logic        store_is_bulk;
    logic [15:0] store_index;
    logic [7:0]  store_byte;
    logic [7:0]  line_length;
    logic [15:0] bulk_received;

    modport source (output valid, output status, output store_valid, output store_is_bulk,
                    output store_index, output store_byte, output line_length,
                    output bulk_received, input ready);
    modport sink   (input valid, input status, input store_valid, input store_is_bulk,
                    input store_index, input store_byte, input line_length,
                    input bulk_received, output ready);
endinterface
`default_nettype wire

/* hw/rtl/at_command_byte_receiver.sv */
// AT command line receiver.
// i_in carries one word per item: op selects a received byte, arm bulk
// receive (with bulk_length), clear frame parser or cancel bulk receive.
// o_out returns exactly one result word per input word: a status code, an
// optional store request (buffer select, index, byte) and the last completed
// line length and bulk byte count.
// A word accepted on i_in sits in the input register; its result is loaded
// into the output register once that register is empty or being read, and
// is then offered on o_out.
// Throughput: one word per cycle while o_out is not stalled; the parser and
// bulk counters update in a single pass of compares and 8/16-bit increments and decrements.
// When o_out stalls, the result holds in the output register and one more
// word is still taken into the input register; i_in.ready drops only when
// both are full.
// Reset (synchronous, active low) empties both registers, puts the parser
// in wait-for-A and turns bulk mode off with its counters cleared.
`default_nettype none
module at_command_byte_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    atcr_in_if.sink           i_in,
    atcr_out_if.source        o_out
);

    logic                     r_in_valid;
    atcr_pkg::t_op            r_op;
    logic [7:0]               r_byte;
    logic [15:0]              r_len;

    atcr_pkg::t_parse_step    r_parse, n_parse;
    atcr_pkg::t_parse_step    r_before, n_before;
    logic [7:0]               r_body, n_body;
    logic [7:0]               r_done, n_done;
    logic                     r_bulk_active, n_bulk_active;
    logic [15:0]              r_bulk_rem, n_bulk_rem;
    logic [15:0]              r_bulk_cnt, n_bulk_cnt;

    logic                     r_out_valid;
    atcr_pkg::t_status        r_status, n_status;
    logic                     r_sv, n_sv;
    logic                     r_sbulk, n_sbulk;
    logic [15:0]              r_si, n_si;
    logic [7:0]               r_sb, n_sb;
    logic [7:0]               r_ll;
    logic [15:0]              r_br;

    logic                     w_move;
    logic                     w_bulk_take;

    assign w_move      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_move;
    assign w_bulk_take = (r_op == atcr_pkg::OP_BYTE) && r_bulk_active && (r_bulk_rem != 16'd0);

    // next state
    always_comb begin
        n_parse       = r_parse;
        n_before      = r_before;
        n_body        = r_body;
        n_done        = r_done;
        n_bulk_active = r_bulk_active;
        n_bulk_rem    = r_bulk_rem;
        n_bulk_cnt    = r_bulk_cnt;
        unique case (r_op)
            atcr_pkg::OP_ARM: begin
                n_bulk_active = (r_len != 16'd0);
                n_bulk_rem    = r_len;
                n_bulk_cnt    = 16'd0;
            end
            atcr_pkg::OP_CLEAR: begin
                n_parse = atcr_pkg::PS_WAIT_A;
                n_done  = 8'd0;
            end
            atcr_pkg::OP_CANCEL: begin
                n_bulk_active = 1'b0;
                n_bulk_rem    = 16'd0;
                n_bulk_cnt    = 16'd0;
            end
            default: begin
                if (w_bulk_take) begin
                    n_bulk_cnt = r_bulk_cnt + 16'd1;
                    n_bulk_rem = r_bulk_rem - 16'd1;
                    if (r_bulk_rem == 16'd1) begin
                        n_bulk_active = 1'b0;
                    end
                end else begin
                    n_bulk_active = 1'b0;
                    if (r_byte == atcr_pkg::CH_CR) begin
                        n_before = r_parse;
                        n_parse  = atcr_pkg::PS_WAIT_LF;
                    end else begin
                        unique case (r_parse)
                            atcr_pkg::PS_WAIT_A: begin
                                n_parse = (r_byte == atcr_pkg::CH_A) ? atcr_pkg::PS_WAIT_T
                                                                     : atcr_pkg::PS_WAIT_A;
                            end
                            atcr_pkg::PS_WAIT_T: begin
                                if (r_byte == atcr_pkg::CH_T) begin
                                    n_body  = 8'd0;
                                    n_parse = atcr_pkg::PS_BODY;
                                end else begin
                                    n_parse = atcr_pkg::PS_WAIT_A;
                                end
                            end
                            atcr_pkg::PS_BODY: begin
                                if (r_body >= atcr_pkg::BODY_MAX) begin
                                    n_parse = atcr_pkg::PS_WAIT_A;
                                end else begin
                                    n_body = r_body + 8'd1;
                                end
                            end
                            default: begin
                                n_parse = atcr_pkg::PS_WAIT_A;
                                if (r_byte == atcr_pkg::CH_LF &&
                                    (r_before == atcr_pkg::PS_BODY ||
                                     r_before == atcr_pkg::PS_WAIT_LF)) begin
                                    n_done = r_body;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    // result
    always_comb begin
        n_status = atcr_pkg::ST_ACK;
        n_sv     = 1'b0;
        n_sbulk  = 1'b0;
        n_si     = 16'd0;
        if (r_op == atcr_pkg::OP_BYTE) begin
            if (w_bulk_take) begin
                n_sv     = 1'b1;
                n_sbulk  = 1'b1;
                n_si     = r_bulk_cnt;
                n_status = (r_bulk_rem == 16'd1) ? atcr_pkg::ST_BULK_DONE
                                                 : atcr_pkg::ST_BULK_BYTE;
            end else if (r_byte == atcr_pkg::CH_CR) begin
                n_status = atcr_pkg::ST_WAIT_LF;
            end else begin
                unique case (r_parse)
                    atcr_pkg::PS_WAIT_A: begin
                        n_status = (r_byte == atcr_pkg::CH_A) ? atcr_pkg::ST_WAIT_T
                                                              : atcr_pkg::ST_NOT_A;
                    end
                    atcr_pkg::PS_WAIT_T: begin
                        n_status = (r_byte == atcr_pkg::CH_T) ? atcr_pkg::ST_IN_BODY
                                                              : atcr_pkg::ST_NOT_T;
                    end
                    atcr_pkg::PS_BODY: begin
                        if (r_body >= atcr_pkg::BODY_MAX) begin
                            n_status = atcr_pkg::ST_OVERFLOW;
                        end else begin
                            n_status = atcr_pkg::ST_IN_BODY;
                            n_sv     = 1'b1;
                            n_si     = {8'd0, r_body};
                        end
                    end
                    default: begin
                        if (r_byte != atcr_pkg::CH_LF) begin
                            n_status = atcr_pkg::ST_NO_LF;
                        end else if (r_before == atcr_pkg::PS_BODY ||
                                     r_before == atcr_pkg::PS_WAIT_LF) begin
                            n_status = atcr_pkg::ST_LINE_OK;
                        end else begin
                            n_status = atcr_pkg::ST_EARLY_CR;
                        end
                    end
                endcase
            end
        end
        n_sb = n_sv ? r_byte : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_op   <= atcr_pkg::t_op'(i_in.op);
            r_byte <= i_in.byte_in;
            r_len  <= i_in.bulk_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse       <= atcr_pkg::PS_WAIT_A;
            r_before      <= atcr_pkg::PS_WAIT_A;
            r_body        <= 8'd0;
            r_done        <= 8'd0;
            r_bulk_active <= 1'b0;
            r_bulk_rem    <= 16'd0;
            r_bulk_cnt    <= 16'd0;
        end else if (w_move) begin
            r_parse       <= n_parse;
            r_before      <= n_before;
            r_body        <= n_body;
            r_done        <= n_done;
            r_bulk_active <= n_bulk_active;
            r_bulk_rem    <= n_bulk_rem;
            r_bulk_cnt    <= n_bulk_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_move) begin
            r_status <= n_status;
            r_sv     <= n_sv;
            r_sbulk  <= n_sbulk;
            r_si     <= n_si;
            r_sb     <= n_sb;
            r_ll     <= n_done;
            r_br     <= n_bulk_cnt;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.store_valid   = r_sv;
    assign o_out.store_is_bulk = r_sbulk;
    assign o_out.store_index   = r_si;
    assign o_out.store_byte    = r_sb;
    assign o_out.line_length   = r_ll;
    assign o_out.bulk_received = r_br;

endmodule
`default_nettype wire

/* hw/rtl/atcr_checker.sv */
`default_nettype none
module atcr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_status,
    input  logic        i_store_valid,
    input  logic        i_store_is_bulk,
    input  logic [15:0] i_store_index,
    input  logic [7:0]  i_store_byte
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_store_valid |->
            !i_store_is_bulk && i_store_index == 16'd0 && i_store_byte == 8'd0)
        else $error("store fields not zero without store request");

    a_ack_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == 4'(atcr_pkg::ST_ACK) |-> !i_store_valid)
        else $error("control word issued a store");

    a_bulk_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_store_is_bulk |->
            i_status == 4'(atcr_pkg::ST_BULK_BYTE) || i_status == 4'(atcr_pkg::ST_BULK_DONE))
        else $error("bulk store with non-bulk status");

    a_body_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_store_valid && !i_store_is_bulk |->
            i_status == 4'(atcr_pkg::ST_IN_BODY) &&
            i_store_index < {8'd0, atcr_pkg::BODY_MAX})
        else $error("body store out of range");

endmodule

bind at_command_byte_receiver atcr_checker u_atcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_store_valid   (o_out.store_valid),
    .i_store_is_bulk (o_out.store_is_bulk),
    .i_store_index   (o_out.store_index),
    .i_store_byte    (o_out.store_byte)
);
`default_nettype wire
